@@ rtl/core/tps_pkg.sv @@
// ----------------------------------------------------------------------------
// tps_pkg: shared types and constants for the two-voice pulse synthesizer
// Holds the note increment table, the configuration layout and the control
// bundle that the top level hands to each voice.
// ----------------------------------------------------------------------------
`default_nettype none

package tps_pkg;

  localparam int unsigned NoteTableSize = 72;
  localparam int unsigned KeyW          = 7;
  localparam int unsigned IncrW         = 13;
  localparam int unsigned PhaseW        = 16;
  localparam int unsigned EnvW          = 16;
  localparam int unsigned LevelW        = 8;
  localparam int unsigned DutyW         = 9;
  localparam int unsigned DivW          = 8;
  localparam int unsigned CfgDataW      = 16;
  localparam int unsigned CfgAddrW      = 2;

  localparam logic [KeyW-1:0]  KeyLow   = 7'd12;
  localparam logic [EnvW-1:0]  EnvStart = 16'hFF00;
  localparam logic [DutyW-1:0] DutyMax  = 9'h1FF;

  localparam logic [7:0]  PulseWidthRst     = 8'd128;
  localparam logic [15:0] DecayStepRst      = 16'h0080;
  localparam logic [7:0]  EnvelopeDivideRst = 8'd32;
  localparam logic [DivW-1:0] TickDivRst    = 8'd1;

  typedef enum logic {
    FuncTick    = 1'b0,
    FuncTrigger = 1'b1
  } func_e;

  typedef enum logic [CfgAddrW-1:0] {
    CfgPulseWidth     = 2'd0,
    CfgDecayStep      = 2'd1,
    CfgEnvelopeDivide = 2'd2
  } cfg_addr_e;

  typedef struct packed {
    logic [7:0]  pulse_width;
    logic [15:0] decay_step;
    logic [7:0]  envelope_divide;
  } cfg_t;

  // Per-voice update strobes, all qualified by the item moving to the output.
  typedef struct packed {
    logic tick;      // sample tick: advance phase
    logic env_tick;  // envelope decay on this tick
    logic trig;      // load increment and restart envelope
  } voice_ctrl_t;

  localparam logic [IncrW-1:0] NoteIncr [NoteTableSize] = '{
    13'd134,  13'd142,  13'd150,  13'd159,  13'd169,  13'd179,
    13'd189,  13'd201,  13'd213,  13'd225,  13'd239,  13'd253,
    13'd268,  13'd284,  13'd301,  13'd319,  13'd338,  13'd358,
    13'd379,  13'd401,  13'd425,  13'd451,  13'd477,  13'd506,
    13'd536,  13'd568,  13'd601,  13'd637,  13'd675,  13'd715,
    13'd758,  13'd803,  13'd851,  13'd901,  13'd955,  13'd1011,
    13'd1072, 13'd1135, 13'd1203, 13'd1274, 13'd1350, 13'd1430,
    13'd1515, 13'd1606, 13'd1701, 13'd1802, 13'd1909, 13'd2023,
    13'd2143, 13'd2271, 13'd2406, 13'd2549, 13'd2700, 13'd2861,
    13'd3031, 13'd3211, 13'd3402, 13'd3604, 13'd3819, 13'd4046,
    13'd4286, 13'd4541, 13'd4811, 13'd5098, 13'd5401, 13'd5722,
    13'd6062, 13'd6422, 13'd6804, 13'd7209, 13'd7638, 13'd8092
  };

  // Returns the increment for a table index; indexes past the end give zero.
  function automatic logic [IncrW-1:0] note_incr(input logic [KeyW-1:0] idx);
    logic [IncrW-1:0] val;
    val = '0;
    if (32'(idx) < NoteTableSize) begin
      val = NoteIncr[idx];
    end
    return val;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/tps_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tps_cfg_regs: configuration register file
// Three write-only registers loaded from a plain indexed write port.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tps_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [tps_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output tps_pkg::cfg_t                      cfg_o
);

  tps_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        tps_pkg::CfgPulseWidth:     cfg_d.pulse_width     = cfg_wdata_i[7:0];
        tps_pkg::CfgDecayStep:      cfg_d.decay_step      = cfg_wdata_i;
        tps_pkg::CfgEnvelopeDivide: cfg_d.envelope_divide = cfg_wdata_i[7:0];
        default: ;  // Unused index: the write is dropped.
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_width     <= tps_pkg::PulseWidthRst;
      cfg_q.decay_step      <= tps_pkg::DecayStepRst;
      cfg_q.envelope_divide <= tps_pkg::EnvelopeDivideRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/tps_voice.sv @@
// ----------------------------------------------------------------------------
// tps_voice: one pulse voice
// Phase accumulator, note increment and linearly decaying envelope, with the
// pulse comparison that gives the voice's present output level.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_voice (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire tps_pkg::cfg_t                cfg_i,
  input  wire tps_pkg::voice_ctrl_t         ctrl_i,
  input  wire logic [tps_pkg::IncrW-1:0]    incr_i,
  output logic [tps_pkg::LevelW-1:0]        level_o
);

  logic [tps_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [tps_pkg::IncrW-1:0]  incr_q, incr_d;
  logic [tps_pkg::EnvW-1:0]   env_q, env_d;

  // Output is silent while the phase high byte is below the pulse width.
  assign level_o = (phase_q[15:8] >= cfg_i.pulse_width) ? env_q[15:8] : '0;

  always_comb begin
    phase_d = phase_q;
    incr_d  = incr_q;
    env_d   = env_q;
    if (ctrl_i.trig) begin
      incr_d = incr_i;
      env_d  = tps_pkg::EnvStart;
    end
    if (ctrl_i.tick) begin
      phase_d = phase_q + tps_pkg::PhaseW'(incr_q);
    end
    if (ctrl_i.env_tick) begin
      env_d = (env_q > cfg_i.decay_step) ? (env_q - cfg_i.decay_step) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      incr_q  <= '0;
      env_q   <= '0;
    end else begin
      phase_q <= phase_d;
      incr_q  <= incr_d;
      env_q   <= env_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/two_voice_pulse_synth.sv @@
// ----------------------------------------------------------------------------
// two_voice_pulse_synth: pulse-wave tone generator producing a PWM duty
// Sample ticks mix the voices into a duty value and advance phases and
// envelopes; trigger transactions load a voice from the note table.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Payload
// s_axis    in         tdata: note_key[6:0]; tuser: func[0], voice_sel[1]
// m_axis    out        tdata: duty[8:0];     tuser: key_error[0]
// cfg       in         index 0 pulse_width, 1 decay_step, 2 envelope_divide
//
// Every input transaction produces exactly one output transaction. A
// transaction waits in the input register, where the mixing and all state
// updates are done in a single pass, and then sits in the output register
// until taken; one transaction per clock is sustained while m_axis is not
// stalled. A stalled output holds the input register, which in turn drops
// s_axis_tready. After reset the voices are silent, the tick divider is one
// and the registers hold their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module two_voice_pulse_synth #(
  parameter int unsigned NUM_VOICES = 2
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Input stream
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,   // [6:0] note_key
  input  wire logic [1:0]                   s_axis_tuser,   // [0] func, [1] voice_sel
  // Output stream
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [15:0]                       m_axis_tdata,   // [8:0] duty
  output logic                              m_axis_tuser,   // [0] key_error
  // Configuration write port
  input  wire logic                         cfg_we_i,
  input  wire logic [tps_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [tps_pkg::CfgDataW-1:0] cfg_wdata_i
);

  // Width of the raw mix; at least the duty width so saturation is uniform.
  localparam int unsigned RawSumW = $clog2(NUM_VOICES * 255 + 1);
  localparam int unsigned SumW    = (RawSumW > tps_pkg::DutyW) ? RawSumW : tps_pkg::DutyW;

  tps_pkg::cfg_t cfg;

  tps_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Input register.
  logic                        in_valid_q;
  tps_pkg::func_e              in_func_q;
  logic                        in_sel_q;
  logic [tps_pkg::KeyW-1:0]    in_key_q;

  // Output register.
  logic                        out_valid_q;
  logic [tps_pkg::DutyW-1:0]   out_duty_q, out_duty_d;
  logic                        out_err_q, out_err_d;

  // Shared tick state.
  logic [tps_pkg::DivW-1:0]    tick_div_q, tick_div_d;
  logic [tps_pkg::DutyW-1:0]   last_duty_q, last_duty_d;

  // The item in the input register moves to the output register this cycle.
  logic advance;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  logic is_tick, is_trig;
  assign is_tick = advance && (in_func_q == tps_pkg::FuncTick);
  assign is_trig = advance && (in_func_q == tps_pkg::FuncTrigger);

  // Key range check and table lookup.
  logic [tps_pkg::KeyW-1:0]  key_idx;
  logic                      key_bad;
  logic [tps_pkg::IncrW-1:0] incr;

  assign key_idx = in_key_q - tps_pkg::KeyLow;
  assign key_bad = (in_key_q < tps_pkg::KeyLow) ||
                   (32'(key_idx) >= tps_pkg::NoteTableSize);
  assign incr    = tps_pkg::note_incr(key_idx);

  // Envelope decay fires when the divider steps down to zero.
  logic [tps_pkg::DivW-1:0] tick_dec;
  logic                     env_fire;
  assign tick_dec = tick_div_q - tps_pkg::DivW'(1);
  assign env_fire = is_tick && (tick_dec == '0);

  always_comb begin
    tick_div_d = tick_div_q;
    if (is_tick) begin
      tick_div_d = env_fire ? cfg.envelope_divide : tick_dec;
    end
  end

  // Voices.
  logic [tps_pkg::LevelW-1:0] level [NUM_VOICES];

  for (genvar v = 0; v < NUM_VOICES; v++) begin : g_voice
    tps_pkg::voice_ctrl_t ctrl;

    assign ctrl.tick     = is_tick;
    assign ctrl.env_tick = env_fire;
    // Voice numbers the select field cannot reach are never triggered.
    assign ctrl.trig     = is_trig && !key_bad && (32'(in_sel_q) == v);

    tps_voice u_voice (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cfg_i   (cfg),
      .ctrl_i  (ctrl),
      .incr_i  (incr),
      .level_o (level[v])
    );
  end

  // Mix the voices with saturation at the duty ceiling.
  logic [SumW-1:0] mix_sum;
  logic [tps_pkg::DutyW-1:0] mix_duty;

  always_comb begin
    mix_sum = '0;
    for (int i = 0; i < NUM_VOICES; i++) begin
      mix_sum = mix_sum + SumW'(level[i]);
    end
    mix_duty = (mix_sum > SumW'(tps_pkg::DutyMax)) ? tps_pkg::DutyMax
                                                   : mix_sum[tps_pkg::DutyW-1:0];
  end

  // A tick reports the fresh mix; a trigger repeats the last one.
  always_comb begin
    last_duty_d = last_duty_q;
    out_duty_d  = last_duty_q;
    out_err_d   = 1'b0;
    if (is_tick) begin
      last_duty_d = mix_duty;
      out_duty_d  = mix_duty;
    end else begin
      out_err_d   = key_bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tick_div_q  <= tps_pkg::TickDivRst;
      last_duty_q <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      tick_div_q  <= tick_div_d;
      last_duty_q <= last_duty_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func_q <= tps_pkg::func_e'(s_axis_tuser[0]);
      in_sel_q  <= s_axis_tuser[1];
      in_key_q  <= s_axis_tdata[6:0];
    end
    if (advance) begin
      out_duty_q <= out_duty_d;
      out_err_q  <= out_err_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_duty_q};
  assign m_axis_tuser  = out_err_q;

  // A trigger result repeats the duty of the last sample tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_trig |=> (out_duty_q == last_duty_q))
    else $error("trigger result duty differs from last tick duty");

  // Sample ticks never report a key error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_tick |=> !out_err_q)
    else $error("key error flagged on a sample tick");

  // The tick divider counts down by one between decay events.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_tick && !env_fire) |=> (tick_div_q == $past(tick_dec)))
    else $error("tick divider did not step down");

  // A held input item is neither lost nor replaced while the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_key_q) && $stable(in_func_q)))
    else $error("input register changed while stalled");

endmodule

`default_nettype wire
